// ===== rtl/core/spq_pkg.sv =====
// Shared types and constants of the sorted priority queue.
// Used by spq_engine and sorted_priority_queue_top; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam logic [4:0] CAPACITY_RESET = 5'd10;

   localparam logic OPCODE_INSERT = 1'b0;
   localparam logic OPCODE_REMOVE = 1'b1;

   localparam logic [1:0] STATUS_INSERTED = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_REMOVED  = 2'd2;
   localparam logic [1:0] STATUS_EMPTY    = 2'd3;

   typedef struct packed {
      logic        opcode;
      logic [15:0] payload_in;
      logic [7:0]  priority_in;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] payload_out;
      logic [7:0]  priority_out;
      logic [4:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic [15:0] payload;
      logic [7:0]  priority_val;
   } entry_type;

endpackage

`default_nettype wire

// ===== rtl/core/spq_engine.sv =====
// Sequencer, entry memory and single priority comparator of the queue.
// Depends on spq_pkg; instantiated by sorted_priority_queue_top.
`timescale 1ns / 1ps
`default_nettype none

module spq_engine #(
   parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire spq_pkg::req_type req,
   input  wire logic [4:0]      limit,
   input  wire logic            take,
   output logic                 ready,
   output logic                 res_valid,
   output spq_pkg::rsp_type     result
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = (CNT_W > 5) ? CNT_W : 5;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_PLACE = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   pos_ff, pos_in;
   spq_pkg::req_type   item_ff, item_in;
   spq_pkg::rsp_type   result_ff, result_in;
   spq_pkg::entry_type rd_data_ff;
   spq_pkg::entry_type mem [DEPTH];

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   spq_pkg::entry_type wr_data;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;

   logic [CNT_W-1:0]   count_m1, count_p1, pos_m1, pos_m2;
   logic               full;
   spq_pkg::entry_type new_entry;

   assign count_m1 = count_ff - CNT_W'(1);
   assign count_p1 = count_ff + CNT_W'(1);
   assign pos_m1   = pos_ff - CNT_W'(1);
   assign pos_m2   = pos_ff - CNT_W'(2);

   assign full = (CMP_W'(count_ff) >= CMP_W'(limit)) ||
                 (CMP_W'(count_ff) >= CMP_W'(DEPTH));

   assign new_entry.payload      = item_ff.payload_in;
   assign new_entry.priority_val = item_ff.priority_in;

   assign ready     = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign result    = result_ff;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      item_in   = item_ff;
      result_in = result_ff;
      wr_en     = 1'b0;
      wr_addr   = pos_ff[ADDR_W-1:0];
      wr_data   = new_entry;
      rd_en     = 1'b0;
      rd_addr   = count_m1[ADDR_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               item_in                = req;
               result_in.payload_out  = '0;
               result_in.priority_out = '0;
               result_in.entry_count  = 5'(count_ff);
               if (req.opcode == spq_pkg::OPCODE_INSERT) begin
                  if (full) begin
                     result_in.status = spq_pkg::STATUS_FULL;
                     state_in         = ST_DONE;
                  end else if (count_ff == '0) begin
                     // empty queue: place directly into slot zero
                     wr_en                = 1'b1;
                     wr_addr              = '0;
                     wr_data.payload      = req.payload_in;
                     wr_data.priority_val = req.priority_in;
                     count_in             = count_p1;
                     result_in.status     = spq_pkg::STATUS_INSERTED;
                     result_in.entry_count = 5'(count_p1);
                     state_in             = ST_DONE;
                  end else begin
                     pos_in   = count_ff;
                     rd_en    = 1'b1;
                     state_in = ST_SCAN;
                  end
               end else begin
                  if (count_ff == '0) begin
                     result_in.status = spq_pkg::STATUS_EMPTY;
                     state_in         = ST_DONE;
                  end else begin
                     rd_en    = 1'b1;
                     state_in = ST_READ;
                  end
               end
            end
         end
         ST_SCAN: begin
            // rd_data_ff holds the slot just below pos
            if (rd_data_ff.priority_val > item_ff.priority_in) begin
               wr_en   = 1'b1;
               wr_data = rd_data_ff;
               pos_in  = pos_m1;
               if (pos_m1 == '0) begin
                  state_in = ST_PLACE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = pos_m2[ADDR_W-1:0];
               end
            end else begin
               wr_en                 = 1'b1;
               count_in              = count_p1;
               result_in.status      = spq_pkg::STATUS_INSERTED;
               result_in.entry_count = 5'(count_p1);
               state_in              = ST_DONE;
            end
         end
         ST_PLACE: begin
            wr_en                 = 1'b1;
            count_in              = count_p1;
            result_in.status      = spq_pkg::STATUS_INSERTED;
            result_in.entry_count = 5'(count_p1);
            state_in              = ST_DONE;
         end
         ST_READ: begin
            count_in               = count_m1;
            result_in.status       = spq_pkg::STATUS_REMOVED;
            result_in.payload_out  = rd_data_ff.payload;
            result_in.priority_out = rd_data_ff.priority_val;
            result_in.entry_count  = 5'(count_m1);
            state_in               = ST_DONE;
         end
         ST_DONE: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      item_ff   <= item_in;
      result_ff <= result_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(DEPTH))
      else $error("stored count above depth");

   a_scan_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (pos_ff != '0 && pos_ff <= count_ff))
      else $error("scan position out of range");

   a_full_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && start && req.opcode == spq_pkg::OPCODE_INSERT && full)
      |=> (count_ff == $past(count_ff)))
      else $error("refused insert changed the count");

   a_result_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (result_ff.entry_count == 5'(count_ff)))
      else $error("reported count differs from stored count");

endmodule

`default_nettype wire

// ===== rtl/core/sorted_priority_queue_top.sv =====
// Sorted priority queue: a memory of up to DEPTH entries kept in ascending
// priority order. An insert walks down from the top slot, moving one entry up
// per cycle through a single memory read/write pair and one priority
// comparator, until it finds an entry of equal or lower priority; if it
// reaches slot zero, a separate place step writes the new entry. A remove
// reads the top slot before its result; a refused insert, an insert into an
// empty queue and a remove from an empty queue go straight to the result. The
// queue takes one request at a time and stalls the request side until its
// result has moved into the output register. There is no clearing pass after
// reset: only slots below the count are ever read.
// Depends on spq_pkg and spq_engine.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue_top #(
   parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire spq_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output spq_pkg::rsp_type      rsp_data,
   input  wire logic             csr_write_enable,
   input  wire logic [4:0]       csr_write_data
);

   logic [4:0]       limit_ff, limit_in;
   logic             rsp_valid_ff, rsp_valid_in;
   spq_pkg::rsp_type rsp_data_ff;

   logic             ready;
   logic             res_valid;
   spq_pkg::rsp_type result;
   logic             start;
   logic             take;

   assign req_stall = !ready;
   assign start     = req_valid && ready;
   // move a finished result when the output register is free or draining
   assign take      = res_valid && (!rsp_valid_ff || !rsp_stall);

   assign limit_in = csr_write_enable ? csr_write_data : limit_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= spq_pkg::CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   spq_engine #(
      .DEPTH (DEPTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req_data),
      .limit     (limit_ff),
      .take      (take),
      .ready     (ready),
      .res_valid (res_valid),
      .result    (result)
   );

endmodule

`default_nettype wire

// ===== tb/spq_result_checker.sv =====
// Result checker for the sorted priority queue: tracks the queue contents,
// predicts every response and compares it field by field with the block.
// Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_result_checker #(
   parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  spq_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  spq_pkg::rsp_type rsp_data,
   input  logic             csr_write_enable,
   input  logic [4:0]       csr_write_data,
   output int               error_count,
   output int               outstanding
);

   spq_pkg::entry_type queue_slots [DEPTH];
   int unsigned        queue_fill;
   logic [4:0]         capacity_reg;
   spq_pkg::rsp_type   expected_responses [$];

   initial begin
      error_count = 0;
      outstanding = 0;
      queue_fill = 0;
      capacity_reg = spq_pkg::CAPACITY_RESET;
   end

   // Apply one request to the tracked queue and return the response it causes.
   function automatic spq_pkg::rsp_type apply_request(spq_pkg::req_type item);
      spq_pkg::rsp_type result;
      int unsigned      slot;
      int unsigned      room;
      result = '0;
      room = (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
      if (item.opcode == spq_pkg::OPCODE_INSERT) begin
         if (queue_fill >= room) begin
            result.status = spq_pkg::STATUS_FULL;
         end else begin
            // Move up every entry of strictly higher priority.
            slot = queue_fill;
            while (slot > 0 && queue_slots[slot - 1].priority_val > item.priority_in) begin
               queue_slots[slot] = queue_slots[slot - 1];
               slot--;
            end
            queue_slots[slot].payload = item.payload_in;
            queue_slots[slot].priority_val = item.priority_in;
            queue_fill++;
            result.status = spq_pkg::STATUS_INSERTED;
         end
      end else if (queue_fill == 0) begin
         result.status = spq_pkg::STATUS_EMPTY;
      end else begin
         queue_fill--;
         result.payload_out = queue_slots[queue_fill].payload;
         result.priority_out = queue_slots[queue_fill].priority_val;
         result.status = spq_pkg::STATUS_REMOVED;
      end
      result.entry_count = 5'(queue_fill);
      return result;
   endfunction

   task automatic report_field(string field, logic [15:0] want, logic [15:0] got);
      error_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
   endtask

   always @(posedge clock) begin
      spq_pkg::rsp_type want;
      if (reset) begin
         queue_fill = 0;
         capacity_reg = spq_pkg::CAPACITY_RESET;
         expected_responses.delete();
      end else begin
         if (csr_write_enable)
            capacity_reg = csr_write_data;
         // Check the response transfer before adding this edge's request.
         if (rsp_valid && !rsp_stall) begin
            if (expected_responses.size() == 0) begin
               error_count++;
               $display("%0t: response with none expected, got %0h", $time, rsp_data);
            end else begin
               want = expected_responses.pop_front();
               if (rsp_data.status !== want.status)
                  report_field("status", 16'(want.status), 16'(rsp_data.status));
               if (rsp_data.payload_out !== want.payload_out)
                  report_field("payload_out", want.payload_out, rsp_data.payload_out);
               if (rsp_data.priority_out !== want.priority_out)
                  report_field("priority_out", 16'(want.priority_out),
                               16'(rsp_data.priority_out));
               if (rsp_data.entry_count !== want.entry_count)
                  report_field("entry_count", 16'(want.entry_count),
                               16'(rsp_data.entry_count));
            end
         end
         if (req_valid && !req_stall)
            expected_responses.push_back(apply_request(req_data));
      end
      outstanding = expected_responses.size();
   end

endmodule

// ===== tb/tb_top.sv =====
// Top of the sorted priority queue testbench: clock, reset, request and
// capacity stimulus, response stalls and the verdict.
// Depends on spq_pkg, sorted_priority_queue_top and spq_result_checker.
`timescale 1ns / 1ps

module tb_top;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   spq_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   spq_pkg::rsp_type rsp_data;
   logic             csr_write_enable = 1'b0;
   logic [4:0]       csr_write_data = '0;

   int error_count;
   int outstanding;

   bit sender_gaps = 1'b1;
   bit receiver_gaps = 1'b1;
   int hold_requests = 0;

   sorted_priority_queue_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   spq_result_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .error_count      (error_count),
      .outstanding      (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // Response side: random stalls, plus a long hold whenever one is asked for.
   initial begin
      int hold_left;
      int holds_served;
      hold_left = 0;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (hold_requests != holds_served) begin
            holds_served++;
            hold_left = 199;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= receiver_gaps && ($urandom_range(0, 99) < 8);
         end
      end
   end

   task automatic send_request(logic op, logic [15:0] tag, logic [7:0] prio);
      if (sender_gaps && $urandom_range(0, 99) < 8) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data.opcode <= op;
      req_data.payload_in <= tag;
      req_data.priority_in <= prio;
      // Hold until the transfer happens.
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(logic [4:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Half the priorities come from a narrow band so that ties are common.
   function automatic logic [7:0] pick_priority();
      if ($urandom_range(0, 1))
         return 8'($urandom_range(0, 3));
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic run_random(int count, int insert_pct);
      logic op;
      for (int i = 0; i < count; i++) begin
         op = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::OPCODE_INSERT
                                                   : spq_pkg::OPCODE_REMOVE;
         send_request(op, 16'($urandom_range(0, 65535)), pick_priority());
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty remove, field extremes, ties, fill past the reset limit.
      send_request(spq_pkg::OPCODE_REMOVE, 16'hFFFF, 8'hFF);
      send_request(spq_pkg::OPCODE_INSERT, 16'h0000, 8'h00);
      send_request(spq_pkg::OPCODE_INSERT, 16'hFFFF, 8'hFF);
      send_request(spq_pkg::OPCODE_INSERT, 16'h1111, 8'd5);
      send_request(spq_pkg::OPCODE_INSERT, 16'h2222, 8'd5);
      send_request(spq_pkg::OPCODE_INSERT, 16'h3333, 8'd200);
      repeat (6) send_request(spq_pkg::OPCODE_REMOVE, 16'h0000, 8'h00);
      for (int i = 0; i < 11; i++)
         send_request(spq_pkg::OPCODE_INSERT, 16'hA000 + 16'(i), 8'(i % 3));
      send_request(spq_pkg::OPCODE_REMOVE, 16'h5A5A, 8'h5A);
      wait_idle();

      // Limit of zero with entries stored: inserts refused, contents kept.
      write_capacity(5'd0);
      send_request(spq_pkg::OPCODE_INSERT, 16'hBEEF, 8'd7);
      run_random(20, 50);
      wait_idle();

      // Limit above the depth: fill to the full depth, then drain.
      write_capacity(5'd31);
      run_random(130, 65);
      run_random(130, 35);
      wait_idle();

      // Limit exactly the depth, with no idling on either side.
      write_capacity(5'd16);
      sender_gaps = 1'b0;
      receiver_gaps = 1'b0;
      run_random(120, 50);
      wait_idle();
      sender_gaps = 1'b1;
      receiver_gaps = 1'b1;

      // Long response hold while requests keep coming.
      write_capacity(5'd6);
      hold_requests++;
      run_random(100, 60);
      wait_idle();

      write_capacity(5'd1);
      run_random(60, 50);
      wait_idle();

      // Fill well up, then lower the limit below the count.
      write_capacity(5'd12);
      run_random(80, 70);
      wait_idle();
      write_capacity(5'd2);
      run_random(60, 50);
      wait_idle();

      repeat (20) @(posedge clock);
      if (error_count == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
